FILE: src/tbt_pkg.sv
`timescale 1ns / 1ps

package tbt_pkg;

  localparam int unsigned NumPads     = 3;
  localparam int unsigned ReadingBits = 16;
  localparam int unsigned MarginBits  = 8;
  localparam int unsigned PhaseBits   = 2;
  localparam int unsigned CfgIdxBits  = 2;

  localparam logic [PhaseBits-1:0] PhaseLast = PhaseBits'(2);

  localparam logic [CfgIdxBits-1:0] CfgMargin0 = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgMargin1 = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CfgMargin2 = CfgIdxBits'(2);

  localparam logic [MarginBits-1:0] MarginReset0 = MarginBits'(10);
  localparam logic [MarginBits-1:0] MarginReset1 = MarginBits'(15);
  localparam logic [MarginBits-1:0] MarginReset2 = MarginBits'(15);

  typedef struct packed {
    logic                   kind;
    logic [ReadingBits-1:0] reading_0;
    logic [ReadingBits-1:0] reading_1;
    logic [ReadingBits-1:0] reading_2;
    logic                   second_elapsed;
    logic                   proximity_busy;
  } in_item_t;

  typedef struct packed {
    logic                   touched_0;
    logic                   touched_1;
    logic                   touched_2;
    logic                   key_latched_0;
    logic                   key_latched_1;
    logic                   key_latched_2;
    logic [ReadingBits-1:0] reference_0;
    logic [ReadingBits-1:0] reference_1;
    logic [ReadingBits-1:0] reference_2;
  } out_item_t;

  // per-item control from the merge stage to the lanes
  typedef struct packed {
    logic step;
    logic recal;
  } lane_ctrl_t;

endpackage

FILE: src/tbt_in_if.sv
`timescale 1ns / 1ps

interface tbt_in_if;
  logic             valid;
  logic             ready;
  tbt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tbt_out_if.sv
`timescale 1ns / 1ps

interface tbt_out_if;
  logic              valid;
  logic              ready;
  tbt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tbt_lane.sv
`timescale 1ns / 1ps

module tbt_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  tbt_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [tbt_pkg::ReadingBits-1:0]     reading_i,
  input  logic [tbt_pkg::MarginBits-1:0]      margin_i,
  output logic                                touch_trk_o,
  output logic [tbt_pkg::ReadingBits-1:0]     reference_o,
  output logic                                touched_o,
  output logic                                key_o
);

  localparam int unsigned RB = tbt_pkg::ReadingBits;
  localparam int unsigned MB = tbt_pkg::MarginBits;

  logic [RB-1:0]        ref_q, ref_d;
  logic                 touched_q, touched_d;
  logic                 key_q, key_d;
  logic [RB-1:0]        ref_trk;
  logic [RB-1:0]        ref_cal;
  logic [RB-1:0]        diff;
  logic [RB-1:0]        margin_ext;
  logic signed [RB:0]   target;
  logic signed [RB:0]   ref_s;
  logic                 touch;

  assign margin_ext = {{(RB-MB){1'b0}}, margin_i};
  assign ref_cal    = reading_i - margin_ext;
  assign diff       = ref_q - reading_i;
  assign target     = $signed({1'b0, reading_i}) - $signed({1'b0, margin_ext});
  assign ref_s      = $signed({1'b0, ref_q});

  always_comb begin
    touch   = 1'b0;
    ref_trk = ref_q;
    if (ref_q > reading_i) begin
      touch = 1'b1;
      if (diff > margin_ext) begin
        ref_trk = ref_q - RB'(1);
      end
    end else if (ctrl_i.step) begin
      if (target > ref_s) begin
        ref_trk = ref_q + RB'(1);
      end else if (target < ref_s) begin
        ref_trk = ref_q - RB'(1);
      end
    end
  end

  always_comb begin
    ref_d     = ref_q;
    touched_d = touched_q;
    key_d     = key_q;
    if (accept_i) begin
      if (ctrl_i.recal) begin
        ref_d     = ref_cal;
        touched_d = 1'b0;
        key_d     = 1'b0;
      end else begin
        ref_d     = ref_trk;
        touched_d = touch;
        key_d     = key_q | touch;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q     <= '0;
      touched_q <= 1'b0;
      key_q     <= 1'b0;
    end else begin
      ref_q     <= ref_d;
      touched_q <= touched_d;
      key_q     <= key_d;
    end
  end

  assign touch_trk_o = touch;
  assign reference_o = ref_q;
  assign touched_o   = touched_q;
  assign key_o       = key_q;

endmodule

FILE: src/tbt_merge.sv
`timescale 1ns / 1ps

module tbt_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          kind_i,
  input  logic                          second_elapsed_i,
  input  logic                          proximity_busy_i,
  input  logic [tbt_pkg::NumPads-1:0]   touch_trk_i,
  output tbt_pkg::lane_ctrl_t           ctrl_o
);

  localparam int unsigned PB = tbt_pkg::PhaseBits;

  logic [PB-1:0] phase_q, phase_d, phase_nxt;

  assign phase_nxt = (phase_q >= tbt_pkg::PhaseLast) ? '0 : phase_q + PB'(1);
  assign phase_d   = (accept_i && !kind_i) ? phase_nxt : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign ctrl_o.step  = (phase_nxt == '0);
  assign ctrl_o.recal = kind_i | (second_elapsed_i & ~proximity_busy_i & ~(|touch_trk_i));

endmodule

FILE: src/touch_baseline_tracker_core.sv
`timescale 1ns / 1ps

// Baseline tracker for three capacitive pads.
// in_i carries one item per handshake: kind (sample or calibrate), one
// filtered reading per pad, the one-second tick and the proximity busy flag.
// out_o returns exactly one item per accepted input item: touched and key
// flags and the reference level of each pad, as they stand after the update.
// cfg_we_i/cfg_idx_i/cfg_data_i write the per-pad margins (index 0..2);
// write only while no item is in flight.
// The result is registered and is valid in the cycle after the input is accepted.
// Throughput: one item per cycle while out_o.ready stays high; the three pad lanes update in parallel and
// the merge stage decides recalibration in the same cycle.
// The lane state registers hold the single result while out_o.ready is low;
// in_i.ready drops only while that result waits and is not being taken.
// Reset clears references, flags and the phase counter and loads the
// default margins (10, 15, 15); no result is pending after reset.
module touch_baseline_tracker_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  tbt_in_if.sink                               in_i,
  tbt_out_if.source                            out_o,
  input  logic                                 cfg_we_i,
  input  logic [tbt_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [tbt_pkg::MarginBits-1:0]       cfg_data_i
);

  localparam int unsigned NP = tbt_pkg::NumPads;
  localparam int unsigned RB = tbt_pkg::ReadingBits;
  localparam int unsigned MB = tbt_pkg::MarginBits;

  logic                 accept;
  logic                 out_valid_q, out_valid_d;
  logic [MB-1:0]        margin_q [NP];
  logic [RB-1:0]        reading [NP];
  logic [RB-1:0]        reference [NP];
  logic [NP-1:0]        touch_trk;
  logic [NP-1:0]        touched;
  logic [NP-1:0]        key;
  tbt_pkg::lane_ctrl_t  ctrl;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign reading[0] = in_i.data.reading_0;
  assign reading[1] = in_i.data.reading_1;
  assign reading[2] = in_i.data.reading_2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q[0] <= tbt_pkg::MarginReset0;
      margin_q[1] <= tbt_pkg::MarginReset1;
      margin_q[2] <= tbt_pkg::MarginReset2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbt_pkg::CfgMargin0: margin_q[0] <= cfg_data_i;
        tbt_pkg::CfgMargin1: margin_q[1] <= cfg_data_i;
        tbt_pkg::CfgMargin2: margin_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tbt_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .kind_i           (in_i.data.kind),
    .second_elapsed_i (in_i.data.second_elapsed),
    .proximity_busy_i (in_i.data.proximity_busy),
    .touch_trk_i      (touch_trk),
    .ctrl_o           (ctrl)
  );

  for (genvar p = 0; p < NP; p++) begin : g_lane
    tbt_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .accept_i    (accept),
      .ctrl_i      (ctrl),
      .reading_i   (reading[p]),
      .margin_i    (margin_q[p]),
      .touch_trk_o (touch_trk[p]),
      .reference_o (reference[p]),
      .touched_o   (touched[p]),
      .key_o       (key[p])
    );
  end

  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // lane state registers double as the output payload
  assign out_o.valid              = out_valid_q;
  assign out_o.data.touched_0     = touched[0];
  assign out_o.data.touched_1     = touched[1];
  assign out_o.data.touched_2     = touched[2];
  assign out_o.data.key_latched_0 = key[0];
  assign out_o.data.key_latched_1 = key[1];
  assign out_o.data.key_latched_2 = key[2];
  assign out_o.data.reference_0   = reference[0];
  assign out_o.data.reference_1   = reference[1];
  assign out_o.data.reference_2   = reference[2];

endmodule

FILE: src/tbt_checker.sv
`timescale 1ns / 1ps

module tbt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_kind_i,
  input logic in_second_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [2:0] touched_i,
  input logic [2:0] key_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("item accepted over a waiting result");

  a_cal_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_kind_i |=> out_valid_i && touched_i == 3'b000 && key_i == 3'b000)
    else $error("calibrate item left flags set");

  a_key_covers_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (touched_i & ~key_i) == 3'b000)
    else $error("touched pad without latched key");

  a_key_clear_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i != 3'b000) ##1 (key_i == 3'b000) |-> $past(in_acc && (in_kind_i || in_second_i)))
    else $error("key flags cleared without calibration");

endmodule

bind touch_baseline_tracker_core tbt_checker u_tbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.data.kind),
  .in_second_i (in_i.data.second_elapsed),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .touched_i   ({out_o.data.touched_2, out_o.data.touched_1, out_o.data.touched_0}),
  .key_i       ({out_o.data.key_latched_2, out_o.data.key_latched_1,
                 out_o.data.key_latched_0})
);
